/* sv/scheme_token_classifier_unit_defines.svh */
// assertion macros for the token classifier checker
// no dependencies; included by files that hold concurrent assertions
`ifndef SCHEME_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH
`define SCHEME_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH

// property checked only outside reset
`define STC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked during reset as well
`define STC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/stc_pkg.sv */
// shared constants, types and byte class helpers for the token classifier
// no dependencies
package stc_pkg;

  // byte codes the classifier looks for
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  // length count saturation and dot count limit
  localparam logic [2:0] POS_MAX  = 3'd7;
  localparam logic [1:0] DOTS_MAX = 2'd2;

  // running token state
  typedef struct packed {
    logic [2:0] position;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       leading_sign;
    logic       all_digits_ok;
    logic       float_chars_ok;
    logic       digit_seen;
    logic [1:0] dot_count;
    logic       quote_parity;
    logic       alnum_tail_ok;
  } tok_state_t;

  localparam tok_state_t TOK_STATE_RESET = '{
    position:       3'd0,
    first_byte:     8'h00,
    second_byte:    8'h00,
    leading_sign:   1'b0,
    all_digits_ok:  1'b1,
    float_chars_ok: 1'b1,
    digit_seen:     1'b0,
    dot_count:      2'd0,
    quote_parity:   1'b0,
    alnum_tail_ok:  1'b1
  };

  // digits 0-9 only
  function automatic logic is_digit_byte(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  // letters A-Z and a-z only
  function automatic logic is_letter_byte(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

endpackage

/* sv/scheme_token_classifier_unit.sv */
// token classifier top level: per-byte state update and class flag result
// depends on stc_pkg
//
//  channel | ports                             | transfer
//  --------+-----------------------------------+------------------------------
//  in      | in_char_code, in_last_char        | in_valid & in_ready, 1 byte
//  out     | out_is_integer .. out_is_atom     | out_valid & out_ready, 1 token
//
// one byte per cycle sustained unless a last byte waits on a full result
// register; a byte goes from the input register through the state update,
// and the last byte of a token writes the result register.
// the input register drains while a result waits unless it holds a last byte.
// reset (rst_n low, synchronous) empties both registers and clears the state.
module scheme_token_classifier_unit
  import stc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_integer,
  output logic       out_is_float,
  output logic       out_is_bool,
  output logic       out_is_char,
  output logic       out_is_string,
  output logic       out_is_atom
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // token state and result register
  tok_state_t st_r, st_nxt, upd;
  logic       out_valid_r;
  logic [5:0] flags_r, flags_nxt;

  logic s1_go;
  logic in_xfer;
  logic first, digit, sign;

  // stage advances unless a last byte meets a full result register
  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_xfer  = in_valid && in_ready;

  // per-byte state update
  always_comb begin
    first = (st_r.position == 3'd0);
    digit = is_digit_byte(s1_char_r);
    sign  = first && (s1_char_r == CH_PLUS || s1_char_r == CH_MINUS);
    upd   = st_r;
    if (first) begin
      upd.first_byte = s1_char_r;
    end else if (st_r.position == 3'd1) begin
      upd.second_byte = s1_char_r;
    end
    if (sign) begin
      upd.leading_sign = 1'b1;
    end else begin
      if (!digit) begin
        upd.all_digits_ok = 1'b0;
      end
      if (s1_char_r == CH_DOT) begin
        if (st_r.dot_count < DOTS_MAX) begin
          upd.dot_count = st_r.dot_count + 2'd1;
        end
      end else if (!digit && !(s1_last_r && s1_char_r == CH_LOWER_F)) begin
        upd.float_chars_ok = 1'b0;
      end
    end
    if (digit) begin
      upd.digit_seen = 1'b1;
    end
    if (!first) begin
      if (s1_char_r == CH_QUOTE) begin
        upd.quote_parity = ~st_r.quote_parity;
      end
      if (!digit && !is_letter_byte(s1_char_r)) begin
        upd.alnum_tail_ok = 1'b0;
      end
    end
    if (st_r.position < POS_MAX) begin
      upd.position = st_r.position + 3'd1;
    end
  end

  // class flags from the updated state, used on the last byte
  always_comb begin
    flags_nxt[0] = upd.all_digits_ok && upd.digit_seen;
    flags_nxt[1] = upd.float_chars_ok && (upd.dot_count <= 2'd1) && upd.digit_seen &&
                   (upd.dot_count == 2'd1 || s1_char_r == CH_LOWER_F);
    flags_nxt[2] = (st_r.position >= 3'd1) && (upd.first_byte == CH_HASH) &&
                   (upd.second_byte == CH_LOWER_T || upd.second_byte == CH_LOWER_F);
    flags_nxt[3] = (st_r.position == 3'd2) && (upd.first_byte == CH_HASH) &&
                   (upd.second_byte == CH_BSLASH) && is_letter_byte(s1_char_r);
    flags_nxt[4] = (st_r.position >= 3'd1) && (upd.first_byte == CH_QUOTE) &&
                   (s1_char_r == CH_QUOTE) && upd.quote_parity;
    flags_nxt[5] = is_letter_byte(upd.first_byte) && upd.alnum_tail_ok;
  end

  // next state: clear after the last byte of a token
  always_comb begin
    st_nxt = st_r;
    if (s1_go) begin
      st_nxt = s1_last_r ? TOK_STATE_RESET : upd;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_xfer) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last_char;
    end
  end

  // token state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= TOK_STATE_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && s1_last_r) begin
      flags_r <= flags_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_integer = flags_r[0];
  assign out_is_float   = flags_r[1];
  assign out_is_bool    = flags_r[2];
  assign out_is_char    = flags_r[3];
  assign out_is_string  = flags_r[4];
  assign out_is_atom    = flags_r[5];

endmodule

/* sv/stc_checker.sv */
// port-level checks for the token classifier, bound to the top level
// depends on scheme_token_classifier_unit_defines.svh
`include "scheme_token_classifier_unit_defines.svh"

module stc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_integer,
  input logic       out_is_float,
  input logic       out_is_bool,
  input logic       out_is_char,
  input logic       out_is_string,
  input logic       out_is_atom
);

  // all six class flags of the result on the ports
  logic [5:0] cls;
  assign cls = {out_is_integer, out_is_float, out_is_bool, out_is_char, out_is_string,
                out_is_atom};

  // a pending result is neither withdrawn nor changed
  `STC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(cls), "result dropped while stalled")

  // a char literal fits no other class
  `STC_ASSERT(a_char_excl, out_valid && out_is_char |-> $onehot(cls), "char token in two classes")

  // an integer fits no other class
  `STC_ASSERT(a_int_excl, out_valid && out_is_integer |-> $onehot(cls), "integer token in two classes")

  // no result straight out of reset
  `STC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // input side never stalls while the result register is empty
  `STC_ASSERT(a_in_flow, in_valid && !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind scheme_token_classifier_unit stc_checker u_stc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_is_integer(out_is_integer),
  .out_is_float  (out_is_float),
  .out_is_bool   (out_is_bool),
  .out_is_char   (out_is_char),
  .out_is_string (out_is_string),
  .out_is_atom   (out_is_atom)
);

/* tb/stc_tb_pkg.sv */
// token class result type and scoreboard for the token classifier bench
// depends on stc_pkg for the byte codes the classifier looks for
`timescale 1ns / 100ps
package stc_tb_pkg;
  import stc_pkg::*;

  // six class flags of one finished token, integer flag in the top bit
  typedef struct packed {
    logic is_integer;
    logic is_float;
    logic is_bool;
    logic is_char;
    logic is_string;
    logic is_atom;
  } tok_class_t;

  class token_scoreboard;
    // running shape of the token under way
    logic [2:0]  tok_len;
    logic [7:0]  lead_byte;
    logic [7:0]  next_byte;
    logic        sign_first;
    logic        digits_only;
    logic        float_shape;
    logic        has_digit;
    logic [1:0]  dots_seen;
    logic        quotes_odd;
    logic        tail_alnum;

    tok_class_t  class_q[$];
    int unsigned errors;
    string       flag_name[6];

    function new();
      errors = 0;
      flag_name = '{"is_atom", "is_string", "is_char", "is_bool", "is_float",
                    "is_integer"};
      clear_token();
    endfunction

    function void clear_token();
      tok_len     = 3'd0;
      lead_byte   = 8'h00;
      next_byte   = 8'h00;
      sign_first  = 1'b0;
      digits_only = 1'b1;
      float_shape = 1'b1;
      has_digit   = 1'b0;
      dots_seen   = 2'd0;
      quotes_odd  = 1'b0;
      tail_alnum  = 1'b1;
    endfunction

    function bit digit_byte(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function bit letter_byte(logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // advance the token shape by one byte; the marked last byte yields a class
    function void note_byte(logic [7:0] c, logic last);
      bit         opening;
      bit         dig;
      bit         sgn;
      tok_class_t cls;
      opening = (tok_len == 3'd0);
      dig     = digit_byte(c);
      sgn     = opening && ((c == CH_PLUS) || (c == CH_MINUS));

      if (opening) lead_byte = c;
      else if (tok_len == 3'd1) next_byte = c;

      // sign only counts in front, every later byte shapes number flags
      if (sgn) begin
        sign_first = 1'b1;
      end else begin
        if (!dig) digits_only = 1'b0;
        if (c == CH_DOT) begin
          if (dots_seen < DOTS_MAX) dots_seen = dots_seen + 2'd1;
        end else if (!dig && !(last && (c == CH_LOWER_F))) begin
          float_shape = 1'b0;
        end
      end
      if (dig) has_digit = 1'b1;
      if (!opening) begin
        if (c == CH_QUOTE) quotes_odd = ~quotes_odd;
        if (!dig && !letter_byte(c)) tail_alnum = 1'b0;
      end

      if (!last) begin
        if (tok_len < POS_MAX) tok_len = tok_len + 3'd1;
        return;
      end

      cls.is_integer = digits_only && has_digit;
      cls.is_float   = float_shape && (dots_seen <= 2'd1) && has_digit &&
                       ((dots_seen == 2'd1) || (c == CH_LOWER_F));
      cls.is_bool    = (tok_len >= 3'd1) && (lead_byte == CH_HASH) &&
                       ((next_byte == CH_LOWER_T) || (next_byte == CH_LOWER_F));
      cls.is_char    = (tok_len == 3'd2) && (lead_byte == CH_HASH) &&
                       (next_byte == CH_BSLASH) && letter_byte(c);
      cls.is_string  = (tok_len >= 3'd1) && (lead_byte == CH_QUOTE) &&
                       (c == CH_QUOTE) && quotes_odd;
      cls.is_atom    = letter_byte(lead_byte) && tail_alnum;
      class_q.push_back(cls);
      clear_token();
    endfunction

    // compare one result transfer with the oldest predicted class
    function void check_result(tok_class_t got);
      tok_class_t  want;
      logic [5:0]  w;
      logic [5:0]  g;
      if (class_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %b", $time, got);
        errors++;
        return;
      end
      want = class_q.pop_front();
      w = want;
      g = got;
      for (int i = 5; i >= 0; i--) begin
        if (w[i] !== g[i]) begin
          $display("%0t: %s expected %0b actual %0b", $time, flag_name[i], w[i], g[i]);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return class_q.size();
    endfunction
  endclass

endpackage

/* tb/tb.sv */
// top of the token classifier bench: clock, reset, byte and result drivers
// depends on stc_pkg, stc_tb_pkg and scheme_token_classifier_unit
`timescale 1ns / 100ps
module tb;
  import stc_pkg::*;
  import stc_tb_pkg::*;

  localparam int unsigned BYTE_BUDGET = 2000;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_code;
  logic       in_last_char;
  logic       out_valid;
  logic       out_ready;
  logic       out_is_integer;
  logic       out_is_float;
  logic       out_is_bool;
  logic       out_is_char;
  logic       out_is_string;
  logic       out_is_atom;

  token_scoreboard sb = new();
  logic [7:0]  tok_bytes[$];
  int unsigned bytes_sent;
  int unsigned cycles;
  logic        calm;

  scheme_token_classifier_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_last_char   (in_last_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_integer (out_is_integer),
    .out_is_float   (out_is_float),
    .out_is_bool    (out_is_bool),
    .out_is_char    (out_is_char),
    .out_is_string  (out_is_string),
    .out_is_atom    (out_is_atom)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side stalls about 30 percent of cycles outside the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 30);
  end

  // watch both channels; a result never comes at the edge of its own byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(tok_class_t'({out_is_integer, out_is_float, out_is_bool,
                                      out_is_char, out_is_string, out_is_atom}));
      if (in_valid && in_ready)
        sb.note_byte(in_char_code, in_last_char);
    end
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] c, input logic last);
    if (!calm) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_token();
    for (int i = 0; i < tok_bytes.size(); i++)
      send_byte(tok_bytes[i], i == tok_bytes.size() - 1);
  endtask

  task automatic send_text(input string s);
    tok_bytes.delete();
    for (int i = 0; i < s.len(); i++) tok_bytes.push_back(s[i]);
    send_token();
  endtask

  task automatic send_one(input logic [7:0] c);
    tok_bytes.delete();
    tok_bytes.push_back(c);
    send_token();
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1)) return 8'h41 + 8'($urandom_range(25));
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  // bytes that steer the class flags, plus the byte range edges
  function automatic logic [7:0] rand_special();
    case ($urandom_range(12))
      0, 1: return rand_digit();
      2, 3: return rand_letter();
      4:    return CH_DOT;
      5:    return CH_LOWER_F;
      6:    return CH_LOWER_T;
      7:    return CH_HASH;
      8:    return CH_BSLASH;
      9:    return $urandom_range(1) ? CH_PLUS : CH_MINUS;
      10:   return CH_QUOTE;
      11:   return $urandom_range(1) ? 8'h00 : 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // build one token, mostly well formed for one class, sometimes broken
  task automatic build_token();
    int unsigned n;
    int unsigned dot_at;
    tok_bytes.delete();
    case ($urandom_range(9))
      // integer
      0: begin
        if ($urandom_range(2) == 0)
          tok_bytes.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        n = $urandom_range(6, 1);
        repeat (n) tok_bytes.push_back(rand_digit());
      end
      // float, dot and or trailing f
      1: begin
        if ($urandom_range(2) == 0)
          tok_bytes.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        n = $urandom_range(5, 1);
        dot_at = $urandom_range(n);
        for (int i = 0; i <= n; i++) begin
          if (i == dot_at && $urandom_range(3) != 0) tok_bytes.push_back(CH_DOT);
          if (i < n) tok_bytes.push_back(rand_digit());
        end
        if ($urandom_range(1)) tok_bytes.push_back(CH_LOWER_F);
      end
      // bool with a tail of up to three letters
      2: begin
        tok_bytes.push_back(CH_HASH);
        tok_bytes.push_back($urandom_range(1) ? CH_LOWER_T : CH_LOWER_F);
        n = $urandom_range(3);
        repeat (n) tok_bytes.push_back(rand_letter());
      end
      // character literal, sometimes too long
      3: begin
        tok_bytes.push_back(CH_HASH);
        tok_bytes.push_back(CH_BSLASH);
        tok_bytes.push_back($urandom_range(3) == 0 ? rand_special() : rand_letter());
        if ($urandom_range(4) == 0) tok_bytes.push_back(rand_letter());
      end
      // string with quotes inside
      4: begin
        tok_bytes.push_back(CH_QUOTE);
        n = $urandom_range(6);
        repeat (n) tok_bytes.push_back($urandom_range(3) == 0 ? CH_QUOTE : rand_letter());
        tok_bytes.push_back(CH_QUOTE);
      end
      // atom
      5: begin
        tok_bytes.push_back(rand_letter());
        n = $urandom_range(8);
        repeat (n) tok_bytes.push_back($urandom_range(1) ? rand_letter() : rand_digit());
      end
      // long token past the length saturation
      6: begin
        n = $urandom_range(20, 8);
        repeat (n) tok_bytes.push_back(rand_special());
      end
      // raw noise over the whole byte range
      7, 8: begin
        n = $urandom_range(6, 1);
        repeat (n) tok_bytes.push_back(8'($urandom_range(255)));
      end
      default: begin
        n = $urandom_range(5, 1);
        repeat (n) tok_bytes.push_back(rand_special());
      end
    endcase
    // occasional single byte corruption
    if ($urandom_range(99) < 15)
      tok_bytes[$urandom_range(tok_bytes.size() - 1)] = rand_special();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = 8'h00;
    in_last_char = 1'b0;
    out_ready    = 1'b0;
    calm         = 1'b0;
    bytes_sent   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed tokens: each class, lone sign, hash and quote, byte edges
    send_text("-7");
    send_text("+");
    send_text("1.5");
    send_text("9f");
    send_text("1..2");
    send_text("#t");
    send_text("#");
    send_text("#\\a");
    send_text("\"a\"");
    send_text("\"");
    send_text("x1");
    send_one(8'h00);
    send_one(8'hFF);

    // random tokens, with a stretch of back to back transfers in the middle
    while (bytes_sent < BYTE_BUDGET) begin
      calm <= (bytes_sent >= BYTE_BUDGET / 3) && (bytes_sent < BYTE_BUDGET / 2);
      build_token();
      send_token();
    end
    calm <= 1'b0;
    in_valid <= 1'b0;

    // drain remaining results, then wait for stray output
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/stc_pkg.sv
sv/scheme_token_classifier_unit.sv
sv/stc_checker.sv
tb/stc_tb_pkg.sv
tb/tb.sv
